FILE: sv/ndt_pkg.sv
`default_nettype none

package ndt_pkg;

  localparam int UUID_W      = 64;
  localparam int ADDR_W      = 48;
  localparam int RND_W       = 16;
  localparam int BASE_W      = 16;
  localparam int PERIOD_W    = 32;
  localparam int DELAY_W     = 33;
  localparam int ID_W        = 6;
  localparam int NCNT_W      = 7;
  localparam int DIV_STEPS   = RND_W;
  localparam int DIV_CNT_W   = $clog2(DIV_STEPS + 1);
  localparam int IN_TDATA_W  = 192;
  localparam int OUT_TDATA_W = 56;
  localparam int PADDR_W     = 3;
  localparam int PDATA_W     = 32;

  localparam logic [BASE_W-1:0]   BASE_RESET   = 16'd10;
  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 32'd10;

  typedef enum logic [1:0] {
    OP_START    = 2'd0,
    OP_TICK     = 2'd1,
    OP_ANNOUNCE = 2'd2,
    OP_REMOVE   = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_SHIFT,
    ST_DIV,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [ADDR_W-1:0] link_addr;
    logic [UUID_W-1:0] uuid_high;
    logic [UUID_W-1:0] uuid_low;
  } row_t;

  // first field in the highest bits
  typedef struct packed {
    logic [NCNT_W-1:0]  neighbor_count;
    logic               removed;
    logic               table_full;
    logic [ID_W-1:0]    new_id;
    logic               is_new;
    logic [DELAY_W-1:0] delay_seconds;
    logic               set_timer;
    logic               send_announce;
  } res_t;

  typedef struct packed {
    logic load_item;
    logic scan;
    logic shift;
    logic start_shift;
    logic set_found;
    logic div_start;
    logic div_step;
    logic finish;
  } cmd_t;

  typedef struct packed {
    op_e  op;
    logic match;
    logic scan_done;
    logic div_done;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

FILE: sv/ndt_ram.sv
`default_nettype none

module ndt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                       wdata_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: sv/ndt_ctrl.sv
`default_nettype none

module ndt_ctrl import ndt_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  input  wire op_e  in_op_i,
  output logic      in_ready_o,
  input  wire sts_t sts_i,
  output cmd_t      cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (in_op_i inside {OP_START, OP_TICK}) begin
            state_d = ST_FINISH;
          end else begin
            state_d = ST_SEARCH;
          end
        end
      end
      ST_SEARCH: begin
        if (sts_i.match) begin
          state_d = (sts_i.op == OP_REMOVE) ? ST_SHIFT : ST_FINISH;
        end else if (sts_i.scan_done) begin
          state_d = (sts_i.op == OP_ANNOUNCE) ? ST_DIV : ST_FINISH;
        end
      end
      ST_SHIFT: begin
        if (sts_i.scan_done) begin
          state_d = ST_FINISH;
        end
      end
      ST_DIV: begin
        if (sts_i.div_done) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (sts_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o      = 1'b1;
        cmd_o.load_item = in_valid_i;
      end
      ST_SEARCH: begin
        cmd_o.scan = 1'b1;
        if (sts_i.match) begin
          cmd_o.set_found   = 1'b1;
          cmd_o.start_shift = (sts_i.op == OP_REMOVE);
        end else if (sts_i.scan_done) begin
          cmd_o.div_start = (sts_i.op == OP_ANNOUNCE);
        end
      end
      ST_SHIFT: begin
        cmd_o.scan  = 1'b1;
        cmd_o.shift = 1'b1;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
      end
      ST_FINISH: begin
        cmd_o.finish = sts_i.out_free;
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

FILE: sv/ndt_dp.sv
`default_nettype none

module ndt_dp import ndt_pkg::*; #(
  parameter int CAPACITY = 64
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire op_e                 in_op_i,
  input  wire logic [UUID_W-1:0]   in_uuid_high_i,
  input  wire logic [UUID_W-1:0]   in_uuid_low_i,
  input  wire logic [ADDR_W-1:0]   in_link_addr_i,
  input  wire logic [RND_W-1:0]    in_random_value_i,
  input  wire logic [BASE_W-1:0]   base_period_i,
  input  wire cmd_t                cmd_i,
  output sts_t                     sts_o,
  input  wire logic                out_ready_i,
  output logic                     out_valid_o,
  output res_t                     out_res_o
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int RW = $bits(row_t);
  localparam logic [CW-1:0] CAP = CW'(CAPACITY);
  localparam logic [CW-1:0] ONE = CW'(1);

  // item
  op_e               op_q;
  logic [UUID_W-1:0] hi_q, lo_q;
  logic [ADDR_W-1:0] addr_q;
  logic [RND_W-1:0]  rnd_q;

  // control state
  logic [CW-1:0]       count_q, count_d, count_nx;
  logic [PERIOD_W-1:0] period_q, period_d, period_nx;
  logic [CW-1:0]       idx_q, idx_d;
  logic [CW-1:0]       cmp_idx_q, cmp_idx_d;
  logic                rd_vld_q, rd_vld_d;
  logic                found_q, found_d;
  logic                out_vld_q, out_vld_d;
  logic [DIV_CNT_W-1:0] div_cnt_q, div_cnt_d;

  // payload
  logic [RND_W-1:0] rem_q, rem_d;
  logic [RND_W-1:0] dvd_q, dvd_d;
  res_t             res_q, res_nx;

  logic          issue;
  logic          append;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [RW-1:0] ram_wdata;
  logic [RW-1:0] ram_rdata;
  row_t          rd_row;
  row_t          new_row;
  logic [CW-1:0] shift_dst;
  logic [RND_W:0] div_t;
  logic          div_ge;
  logic [RND_W-1:0] mod_v;
  logic [PERIOD_W:0] dbl;
  logic [PERIOD_W-1:0] sat;

  assign issue     = cmd_i.scan && (idx_q < count_q);
  assign shift_dst = cmp_idx_q - ONE;
  assign rd_row    = row_t'(ram_rdata);
  assign append    = cmd_i.finish && (op_q == OP_ANNOUNCE) && !found_q && (count_q < CAP);

  always_comb begin
    new_row           = '0;
    new_row.id        = ID_W'(count_q);
    new_row.link_addr = addr_q;
    new_row.uuid_high = hi_q;
    new_row.uuid_low  = lo_q;
  end

  assign ram_we    = (cmd_i.shift && rd_vld_q) || append;
  assign ram_waddr = cmd_i.shift ? shift_dst[AW-1:0] : count_q[AW-1:0];
  assign ram_wdata = cmd_i.shift ? ram_rdata : RW'(new_row);

  ndt_ram #(
    .WIDTH(RW),
    .DEPTH(CAPACITY)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(idx_q[AW-1:0]),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    idx_d     = idx_q;
    rd_vld_d  = issue && !cmd_i.start_shift;
    cmp_idx_d = issue ? idx_q : cmp_idx_q;
    found_d   = found_q;
    if (cmd_i.load_item) begin
      idx_d   = '0;
      found_d = 1'b0;
    end else if (cmd_i.start_shift) begin
      idx_d = cmp_idx_q + ONE;
    end else if (issue) begin
      idx_d = idx_q + ONE;
    end
    if (cmd_i.set_found) begin
      found_d = 1'b1;
    end
  end

  // restoring remainder, one bit per step
  assign div_t  = {rem_q, dvd_q[RND_W-1]};
  assign div_ge = div_t >= {1'b0, base_period_i};

  always_comb begin
    rem_d     = rem_q;
    dvd_d     = dvd_q;
    div_cnt_d = div_cnt_q;
    if (cmd_i.div_start) begin
      rem_d     = '0;
      dvd_d     = rnd_q;
      div_cnt_d = '0;
    end else if (cmd_i.div_step && (div_cnt_q != DIV_CNT_W'(DIV_STEPS))) begin
      rem_d     = div_ge ? RND_W'(div_t - {1'b0, base_period_i}) : div_t[RND_W-1:0];
      dvd_d     = {dvd_q[RND_W-2:0], 1'b0};
      div_cnt_d = div_cnt_q + DIV_CNT_W'(1);
    end
  end

  assign mod_v = (base_period_i == '0) ? '0 : rem_q;
  assign dbl   = {period_q, 1'b0};
  assign sat   = dbl[PERIOD_W] ? '1 : dbl[PERIOD_W-1:0];

  always_comb begin
    res_nx    = '0;
    count_nx  = count_q;
    period_nx = period_q;
    case (op_q)
      OP_START: begin
        count_nx             = '0;
        period_nx            = PERIOD_W'(base_period_i);
        res_nx.send_announce = 1'b1;
        res_nx.set_timer     = 1'b1;
        res_nx.delay_seconds = DELAY_W'(base_period_i);
      end
      OP_TICK: begin
        period_nx            = sat;
        res_nx.send_announce = 1'b1;
        res_nx.set_timer     = 1'b1;
        res_nx.delay_seconds = {1'b0, sat} + DELAY_W'(rnd_q[0]);
      end
      OP_ANNOUNCE: begin
        if (!found_q) begin
          res_nx.is_new = 1'b1;
          if (count_q < CAP) begin
            res_nx.new_id = ID_W'(count_q);
            count_nx      = count_q + ONE;
          end else begin
            res_nx.table_full = 1'b1;
          end
          period_nx            = PERIOD_W'(base_period_i);
          res_nx.set_timer     = 1'b1;
          res_nx.delay_seconds = DELAY_W'(mod_v) + DELAY_W'(2);
        end
      end
      OP_REMOVE: begin
        if (found_q) begin
          count_nx       = count_q - ONE;
          res_nx.removed = 1'b1;
        end
      end
      default: ;
    endcase
    res_nx.neighbor_count = NCNT_W'(count_nx);
  end

  assign count_d   = cmd_i.finish ? count_nx : count_q;
  assign period_d  = cmd_i.finish ? period_nx : period_q;
  assign out_vld_d = cmd_i.finish ? 1'b1 : (out_ready_i ? 1'b0 : out_vld_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      period_q  <= PERIOD_RESET;
      idx_q     <= '0;
      cmp_idx_q <= '0;
      rd_vld_q  <= 1'b0;
      found_q   <= 1'b0;
      out_vld_q <= 1'b0;
      div_cnt_q <= '0;
    end else begin
      count_q   <= count_d;
      period_q  <= period_d;
      idx_q     <= idx_d;
      cmp_idx_q <= cmp_idx_d;
      rd_vld_q  <= rd_vld_d;
      found_q   <= found_d;
      out_vld_q <= out_vld_d;
      div_cnt_q <= div_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      op_q   <= in_op_i;
      hi_q   <= in_uuid_high_i;
      lo_q   <= in_uuid_low_i;
      addr_q <= in_link_addr_i;
      rnd_q  <= in_random_value_i;
    end
    rem_q <= rem_d;
    dvd_q <= dvd_d;
    if (cmd_i.finish) begin
      res_q <= res_nx;
    end
  end

  always_comb begin
    sts_o           = '0;
    sts_o.op        = op_q;
    sts_o.match     = rd_vld_q && (rd_row.uuid_high == hi_q) && (rd_row.uuid_low == lo_q);
    sts_o.scan_done = !rd_vld_q && !(idx_q < count_q);
    sts_o.div_done  = (div_cnt_q == DIV_CNT_W'(DIV_STEPS));
    sts_o.out_free  = !out_vld_q || out_ready_i;
  end

  assign out_valid_o = out_vld_q;
  assign out_res_o   = res_q;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CAP)
    else $error("neighbor count above capacity");

  a_read_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_vld_q |-> (cmp_idx_q < count_q))
    else $error("table read beyond stored entries");

  a_start_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.finish && (op_q == OP_START)) |=> (count_q == '0))
    else $error("start did not empty the table");

  a_remove_dec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.finish && (op_q == OP_REMOVE) && found_q) |=> (count_q == $past(count_q) - ONE))
    else $error("removal did not shrink the table by one");

  a_result_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish |=> out_vld_q)
    else $error("finished item left no result");
`endif

endmodule

`default_nettype wire

FILE: sv/neighbor_discovery_table.sv
// Start and tick go straight to the result. An announcement searches the stored entries up to
//   a match, else over all of them; a new identifier then computes the remainder bit by bit
//   before its result. A removal searches as above, then on a match moves later entries down.
// One item at a time; the next is accepted in the cycle after a result is loaded; a waiting
//   result holds back only the following item.
// Reset (async, active low): count 0, period and base period 10; table contents undefined.
`default_nettype none

module neighbor_discovery_table import ndt_pkg::*; #(
  parameter int CAPACITY = 64
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  // uuid_high[63:0], uuid_low[127:64], link_addr[175:128], random_value[191:176]
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata_i,
  // op[1:0]
  input  wire logic [1:0]             s_axis_tuser_i,
  output logic                        m_axis_tvalid_o,
  input  wire logic                   m_axis_tready_i,
  // send_announce[0], set_timer[1], delay_seconds[34:2], is_new[35], new_id[41:36],
  // table_full[42], removed[43], neighbor_count[50:44], zero[55:51]
  output logic [OUT_TDATA_W-1:0]      m_axis_tdata_o,
  input  wire logic                   psel,
  input  wire logic                   penable,
  input  wire logic                   pwrite,
  input  wire logic [PADDR_W-1:0]     paddr,
  input  wire logic [PDATA_W-1:0]     pwdata,
  output logic [PDATA_W-1:0]          prdata,
  output logic                        pready
);

  logic [BASE_W-1:0] base_q;
  logic              cfg_wr;
  cmd_t              cmd;
  sts_t              sts;
  res_t              res;
  op_e               in_op;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = paddr[2] ? '0 : PDATA_W'(base_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= BASE_RESET;
    end else if (cfg_wr && !paddr[2]) begin
      base_q <= pwdata[BASE_W-1:0];
    end
  end

  assign in_op = op_e'(s_axis_tuser_i);

  ndt_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid_i),
    .in_op_i   (in_op),
    .in_ready_o(s_axis_tready_o),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  ndt_dp #(
    .CAPACITY(CAPACITY)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_op_i          (in_op),
    .in_uuid_high_i   (s_axis_tdata_i[63:0]),
    .in_uuid_low_i    (s_axis_tdata_i[127:64]),
    .in_link_addr_i   (s_axis_tdata_i[175:128]),
    .in_random_value_i(s_axis_tdata_i[191:176]),
    .base_period_i    (base_q),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .out_ready_i      (m_axis_tready_i),
    .out_valid_o      (m_axis_tvalid_o),
    .out_res_o        (res)
  );

  assign m_axis_tdata_o = OUT_TDATA_W'(res);

endmodule

`default_nettype wire
